@@ rtl/mctt_pkg.sv @@
// Shared types and constants for the multi-context timeslice ticker.
// Used by the controller, the datapath and the top level; no dependencies.
`timescale 1ns / 1ps
`default_nettype none
package mctt_pkg;
	localparam int MaxContexts = 8;
	localparam int SlotW = $clog2(MaxContexts);

	localparam logic [2:0] KindRegister   = 3'd0;
	localparam logic [2:0] KindUnregister = 3'd1;
	localparam logic [2:0] KindGlobalTick = 3'd2;
	localparam logic [2:0] KindSelfTick   = 3'd3;
	localparam logic [2:0] KindTake       = 3'd4;

	localparam logic [0:0] CfgTickPeriod = 1'd0;
	localparam logic [0:0] CfgTimeslice  = 1'd1;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic lookup;
		logic div_start;
		logic apply_reg;
		logic apply_unreg;
		logic apply_self;
		logic apply_take;
		logic gtick_step;
		logic [SlotW-1:0] gslot;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic div_busy;
		logic elapsed_ok;
		logic [MaxContexts-1:0] live;
	} status_t;
endpackage
`default_nettype wire

@@ rtl/mctt_datapath.sv @@
// Datapath: context table, slot search, serial 64-bit divider, result register.
// Depends on mctt_pkg; driven by mctt_ctrl through cmd_t.
`timescale 1ns / 1ps
`default_nettype none
module mctt_datapath (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire mctt_pkg::cmd_t      cmd,
	output mctt_pkg::status_t        status,
	input  wire logic [2:0]          kind,
	input  wire logic [15:0]         context_handle,
	input  wire logic [63:0]         now_us,
	input  wire logic                deliver_now,
	input  wire logic                cfg_we,
	input  wire logic [0:0]          cfg_index,
	input  wire logic [19:0]         cfg_data,
	output logic [2:0]               r_slot,
	output logic                     r_found,
	output logic                     r_sw,
	output logic                     r_wake,
	output logic [31:0]              r_pend
);
	localparam int N = mctt_pkg::MaxContexts;
	localparam int SW = mctt_pkg::SlotW;

	logic [19:0] period_q;
	logic [7:0]  slice_q;
	logic [15:0] hnd_q [N];
	logic [N-1:0] act_q, flag_q;
	logic [31:0] pend_q [N];
	logic [7:0]  cd_q [N];
	logic [63:0] time_q [N];

	logic [15:0] h_q;
	logic [63:0] now_q;
	logic        dl_q;
	logic [SW-1:0] s_q;
	logic        hit_q;
	logic [63:0] el_q;

	// divider
	logic [63:0] quo_q, rem_q;
	logic [6:0]  dcnt_q;
	logic [20:0] dvs;
	logic [64:0] trial;

	assign dvs = (period_q == 20'd0) ? 21'd1 : {1'b0, period_q};
	assign trial = {rem_q, quo_q[63]} - {44'd0, dvs};

	// lookup
	logic [SW-1:0] act_s, free_s, any_s;
	logic act_f, free_f, any_f;
	always_comb begin
		act_s = '0; free_s = '0; any_s = '0;
		act_f = 1'b0; free_f = 1'b0; any_f = 1'b0;
		for (int i = N - 1; i >= 0; i--) begin
			if (act_q[i] && hnd_q[i] == h_q) begin act_s = SW'(i); act_f = 1'b1; end
			if (!act_q[i]) begin free_s = SW'(i); free_f = 1'b1; end
			if (hnd_q[i] == h_q) begin any_s = SW'(i); any_f = 1'b1; end
		end
	end

	// charge arithmetic on one slot with n ticks
	function automatic logic [7:0] next_cd(input logic [7:0] c, input logic [31:0] n,
			input logic [7:0] t, input logic [31:0] rmod);
		logic [31:0] ce;
		ce = (c == 8'd0) ? 32'd1 : {24'd0, c};
		if (n < ce) next_cd = c - n[7:0];
		else if (t == 8'd0) next_cd = 8'd0;
		else next_cd = t - rmod[7:0];
	endfunction

	// remainder of (n - ce) mod t for self tick, computed serially after the divide
	logic [31:0] mrem_q;
	logic [5:0]  mcnt_q;
	logic [31:0] nself;
	logic [31:0] ce_s;
	assign nself = quo_q[31:0];
	assign ce_s = (cd_q[s_q] == 8'd0) ? 32'd1 : {24'd0, cd_q[s_q]};

	logic [31:0] mval_q;
	logic [8:0]  mtr;
	assign mtr = {mrem_q[7:0], mval_q[31]} - {1'b0, slice_q};

	// live mask reported with zero-handle entries removed
	logic [N-1:0] live_h;
	always_comb for (int i = 0; i < N; i++) live_h[i] = act_q[i] && hnd_q[i] != 16'd0;

	assign status.div_busy = (dcnt_q != 7'd0) || (mcnt_q != 6'd0);
	assign status.elapsed_ok = hit_q && (el_q >= {44'd0, dvs});
	assign status.live = live_h;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q <= 20'd4000;
			slice_q <= 8'd3;
			act_q <= '0;
			flag_q <= '0;
			dcnt_q <= '0;
			mcnt_q <= '0;
			for (int i = 0; i < N; i++) begin
				hnd_q[i] <= '0;
				pend_q[i] <= '0;
			end
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					mctt_pkg::CfgTickPeriod: period_q <= cfg_data;
					mctt_pkg::CfgTimeslice: slice_q <= cfg_data[7:0];
					default: ;
				endcase
			end
			if (cmd.load) begin
				h_q <= context_handle; now_q <= now_us; dl_q <= deliver_now;
			end
			if (cmd.lookup) begin
				s_q <= act_s;
				hit_q <= act_f && h_q != 16'd0;
				el_q <= now_q - time_q[act_s];
			end
			if (cmd.div_start) begin
				quo_q <= el_q; rem_q <= '0; dcnt_q <= 7'd64;
			end else if (dcnt_q != 7'd0) begin
				if (!trial[64]) begin
					rem_q <= trial[63:0];
					quo_q <= {quo_q[62:0], 1'b1};
				end else begin
					rem_q <= {rem_q[62:0], quo_q[63]};
					quo_q <= {quo_q[62:0], 1'b0};
				end
				dcnt_q <= dcnt_q - 7'd1;
				if (dcnt_q == 7'd1) begin
					// start the slice remainder pass on n - ce
					mval_q <= (trial[64] ? {quo_q[30:0], 1'b0} : {quo_q[30:0], 1'b1})
						- ce_s;
					mrem_q <= '0;
					mcnt_q <= (slice_q == 8'd0) ? 6'd0 : 6'd32;
				end
			end else if (mcnt_q != 6'd0) begin
				if (!mtr[8]) mrem_q <= {24'd0, mtr[7:0]};
				else mrem_q <= {mrem_q[30:0], mval_q[31]};
				mval_q <= {mval_q[30:0], 1'b0};
				mcnt_q <= mcnt_q - 6'd1;
			end

			if (cmd.apply_reg) begin
				r_pend <= '0; r_sw <= 1'b0; r_wake <= 1'b0;
				if (h_q != 16'd0 && !act_f && free_f) begin
					hnd_q[free_s] <= h_q; act_q[free_s] <= 1'b1;
					pend_q[free_s] <= '0; cd_q[free_s] <= slice_q;
					time_q[free_s] <= now_q;
					r_slot <= 3'(free_s); r_found <= 1'b1;
				end else begin
					r_slot <= act_f && h_q != 16'd0 ? 3'(act_s) : 3'd0;
					r_found <= act_f && h_q != 16'd0;
				end
			end
			if (cmd.apply_unreg) begin
				r_pend <= '0; r_sw <= 1'b0; r_wake <= 1'b0;
				r_found <= any_f && h_q != 16'd0;
				r_slot <= (any_f && h_q != 16'd0) ? 3'(any_s) : 3'd0;
				if (any_f && h_q != 16'd0) begin
					act_q[any_s] <= 1'b0; hnd_q[any_s] <= '0;
				end
			end
			if (cmd.apply_self) begin
				logic fl;
				fl = flag_q[s_q];
				r_pend <= '0; r_wake <= 1'b0;
				r_found <= hit_q;
				r_slot <= hit_q ? 3'(s_q) : 3'd0;
				if (hit_q && status.elapsed_ok) begin
					time_q[s_q] <= time_q[s_q] + 64'(nself) * 64'(dvs);
					pend_q[s_q] <= pend_q[s_q] + nself;
					if (nself != 32'd0) begin
						cd_q[s_q] <= next_cd(cd_q[s_q], nself, slice_q, mrem_q);
						if (nself >= ce_s) fl = 1'b1;
					end
				end
				r_sw <= hit_q && dl_q && fl;
				if (hit_q) flag_q[s_q] <= dl_q ? 1'b0 : fl;
			end
			if (cmd.apply_take) begin
				r_sw <= 1'b0; r_wake <= 1'b0;
				r_found <= hit_q;
				r_slot <= hit_q ? 3'(s_q) : 3'd0;
				r_pend <= hit_q ? pend_q[s_q] : 32'd0;
				if (hit_q) pend_q[s_q] <= '0;
			end
			if (cmd.gtick_step) begin
				// charge one tick and deliver at once: flag ends clear
				logic [7:0] c;
				c = cd_q[cmd.gslot];
				pend_q[cmd.gslot] <= pend_q[cmd.gslot] + 32'd1;
				r_sw <= flag_q[cmd.gslot] || c <= 8'd1;
				flag_q[cmd.gslot] <= 1'b0;
				if (c > 8'd1) cd_q[cmd.gslot] <= c - 8'd1;
				else cd_q[cmd.gslot] <= slice_q;
				r_slot <= 3'(cmd.gslot); r_found <= 1'b1; r_wake <= 1'b1; r_pend <= '0;
			end
			// unused kinds and an empty global tick report an all-zero result
			if (cmd.load && (kind > mctt_pkg::KindTake || kind == mctt_pkg::KindGlobalTick))
			begin
				r_slot <= '0; r_found <= 1'b0; r_sw <= 1'b0; r_wake <= 1'b0; r_pend <= '0;
			end
		end
	end
endmodule
`default_nettype wire

@@ rtl/mctt_ctrl.sv @@
// Controller state machine: sequences lookup, divide, table update and output.
// Depends on mctt_pkg; commands mctt_datapath.
`timescale 1ns / 1ps
`default_nettype none
module mctt_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire logic [2:0]        kind,
	input  wire mctt_pkg::status_t status,
	output mctt_pkg::cmd_t         cmd,
	output logic                   out_valid,
	input  wire logic              out_stall,
	output logic                   r_last,
	input  wire logic              g_none
);
	localparam int N = mctt_pkg::MaxContexts;
	localparam int SW = mctt_pkg::SlotW;
	typedef enum logic [2:0] {Idle, Look, Div, Apply, GScan, Emit} st_t;
	st_t st_q;
	logic [2:0] kind_q;
	logic [N-1:0] todo_q;
	logic [SW-1:0] gs;
	logic gmore;
	logic div_go_q;

	always_comb begin
		gs = '0;
		for (int i = N - 1; i >= 0; i--) if (todo_q[i]) gs = SW'(i);
	end
	assign gmore = (todo_q & ~(N'(1) << gs)) != '0;

	assign in_stall = st_q != Idle;
	always_comb begin
		cmd = '0;
		cmd.load = in_valid && st_q == Idle;
		cmd.lookup = st_q == Look;
		cmd.gslot = gs;
		cmd.gtick_step = st_q == GScan && todo_q != '0 && !(out_valid && out_stall);
		cmd.apply_reg = st_q == Apply && kind_q == mctt_pkg::KindRegister;
		cmd.apply_unreg = st_q == Apply && kind_q == mctt_pkg::KindUnregister;
		cmd.apply_take = st_q == Apply && kind_q == mctt_pkg::KindTake;
		cmd.apply_self = st_q == Apply && kind_q == mctt_pkg::KindSelfTick;
		cmd.div_start = st_q == Div && !status.div_busy && !div_go_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= Idle; out_valid <= 1'b0; r_last <= 1'b0; todo_q <= '0; div_go_q <= 1'b0;
		end else begin
			if (out_valid && !out_stall) out_valid <= 1'b0;
			case (st_q)
				Idle: if (in_valid) begin
					kind_q <= kind;
					if (kind == mctt_pkg::KindGlobalTick) st_q <= GScan;
					else if (kind > mctt_pkg::KindTake) begin
						st_q <= Emit; out_valid <= 1'b1; r_last <= 1'b1;
					end else st_q <= Look;
					todo_q <= status.live;
				end
				Look: begin
					div_go_q <= 1'b0;
					st_q <= (kind_q == mctt_pkg::KindSelfTick) ? Div : Apply;
				end
				Div: begin
					if (!div_go_q) div_go_q <= 1'b1;
					else if (!status.div_busy) st_q <= Apply;
				end
				Apply: if (!out_valid || !out_stall) begin
					out_valid <= 1'b1; r_last <= 1'b1; st_q <= Emit;
				end
				GScan: if (!(out_valid && out_stall)) begin
					if (todo_q == '0 || g_none) begin
						// nothing live: one empty result
						out_valid <= 1'b1; r_last <= 1'b1;
						st_q <= Emit;
					end else begin
						out_valid <= 1'b1; r_last <= !gmore;
						todo_q <= todo_q & ~(N'(1) << gs);
						if (!gmore) st_q <= Emit;
					end
				end
				Emit: if (!out_valid || !out_stall) st_q <= Idle;
				default: st_q <= Idle;
			endcase
		end
	end

	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		st_q != Idle |-> in_stall) else $error("input taken while busy");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid) else $error("result dropped");
	a_div: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_start |-> st_q == Div) else $error("divide outside self tick");
endmodule
`default_nettype wire

@@ rtl/multi_context_timeslice_ticker_unit.sv @@
// Top level of the multi-context timeslice ticker.
// Depends on mctt_pkg, mctt_ctrl and mctt_datapath.
`timescale 1ns / 1ps
`default_nettype none
// One item at a time. Register, unregister and take step through lookup, apply and
// emit; a self tick adds a restoring 64-bit divide by the tick period and, for a
// nonzero timeslice, a remainder pass by the timeslice. A global tick gives one
// result per active slot, lowest slot first, one a cycle unless the output stalls.
// Configuration writes are taken at any edge but belong to idle time.
module multi_context_timeslice_ticker_unit (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [2:0]  kind,
	input  wire logic [15:0] context_handle,
	input  wire logic [63:0] now_us,
	input  wire logic        deliver_now,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [2:0]       slot,
	output logic             found,
	output logic             switch_request,
	output logic             wake,
	output logic [31:0]      pending_count,
	output logic             last,
	input  wire logic        cfg_we,
	input  wire logic [0:0]  cfg_index,
	input  wire logic [19:0] cfg_data
);
	mctt_pkg::cmd_t    cmd;
	mctt_pkg::status_t status;
	logic gnone;
	// a global tick with nothing live gives one empty result
	assign gnone = status.live == '0;

	mctt_ctrl u_ctrl (
		.clk, .arst_n, .in_valid, .in_stall, .kind, .status, .cmd,
		.out_valid, .out_stall, .r_last(last), .g_none(gnone)
	);
	mctt_datapath u_dp (
		.clk, .arst_n, .cmd, .status, .kind, .context_handle, .now_us, .deliver_now,
		.cfg_we, .cfg_index, .cfg_data,
		.r_slot(slot), .r_found(found), .r_sw(switch_request), .r_wake(wake),
		.r_pend(pending_count)
	);
endmodule
`default_nettype wire

@@ test/multi_context_timeslice_ticker_unit_tb.sv @@
// Self-checking testbench for multi_context_timeslice_ticker_unit.
// A directed table and then random items are driven through the valid/stall handshake.
// Each result is checked against an in-bench predictor of the context table; depends on mctt_pkg.
`timescale 1ns / 1ps
module multi_context_timeslice_ticker_unit_tb;
	localparam int NumDirected = 27;

	typedef struct packed {
		logic [2:0]  slot;
		logic        found;
		logic        switch_request;
		logic        wake;
		logic [31:0] pending_count;
		logic        last;
	} tick_result_t;

	// One row of the directed table; when known is set the typed result replaces
	// the predicted one (single result, no switch, no wake, last set).
	typedef struct {
		logic [2:0]  kind;
		logic [15:0] handle;
		logic [63:0] now;
		logic        dl;
		logic        known;
		logic [2:0]  slot;
		logic        found;
		logic [31:0] pend;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [2:0] kind = '0;
	logic [15:0] context_handle = '0;
	logic [63:0] now_us = '0;
	logic deliver_now = 1'b0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [2:0] slot;
	logic found;
	logic switch_request;
	logic wake;
	logic [31:0] pending_count;
	logic last;
	logic cfg_we = 1'b0;
	logic [0:0] cfg_index = '0;
	logic [19:0] cfg_data = '0;

	multi_context_timeslice_ticker_unit u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.kind(kind), .context_handle(context_handle), .now_us(now_us),
		.deliver_now(deliver_now),
		.out_valid(out_valid), .out_stall(out_stall),
		.slot(slot), .found(found), .switch_request(switch_request), .wake(wake),
		.pending_count(pending_count), .last(last),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #10 clk = ~clk;

	// Predictor copy of the context table and its two registers.
	logic [19:0] period_reg;
	logic [7:0]  slice_reg;
	logic [15:0] ctx_handle [mctt_pkg::MaxContexts];
	logic        ctx_active [mctt_pkg::MaxContexts];
	logic [31:0] ctx_ticks  [mctt_pkg::MaxContexts];
	logic [7:0]  ctx_slice  [mctt_pkg::MaxContexts];
	logic        ctx_switch [mctt_pkg::MaxContexts];
	logic [63:0] ctx_stamp  [mctt_pkg::MaxContexts];

	tick_result_t tick_results_q [$];
	int  errors = 0;
	bit  tx_idle_on = 1'b1;
	bit  rx_idle_on = 1'b1;
	logic [63:0] wall_us = 64'd0;
	stim_row_t directed [NumDirected];

	task automatic table_reset();
		period_reg = 20'd4000;
		slice_reg = 8'd3;
		for (int i = 0; i < mctt_pkg::MaxContexts; i++) begin
			ctx_handle[i] = '0;
			ctx_active[i] = 1'b0;
			ctx_ticks[i] = '0;
			ctx_slice[i] = '0;
			ctx_switch[i] = 1'b0;
			ctx_stamp[i] = '0;
		end
	endtask

	// Add n ticks to one context and run its timeslice countdown.
	task automatic charge_ticks(input int i, input logic [31:0] n);
		logic [31:0] c, ce, t, rem;
		ctx_ticks[i] = ctx_ticks[i] + n;
		if (n != 0) begin
			c = {24'd0, ctx_slice[i]};
			ce = (c == 0) ? 32'd1 : c;
			t = {24'd0, slice_reg};
			if (n < ce) begin
				ctx_slice[i] = 8'(c - n);
			end else begin
				ctx_switch[i] = 1'b1;
				rem = n - ce;
				ctx_slice[i] = (t == 0) ? 8'd0 : 8'(t - (rem % t));
			end
		end
	endtask

	function automatic int find_live(input logic [15:0] h);
		if (h == 0)
			return -1;
		for (int i = 0; i < mctt_pkg::MaxContexts; i++)
			if (ctx_active[i] && ctx_handle[i] == h)
				return i;
		return -1;
	endfunction

	function automatic tick_result_t single(input int s, input logic sw, input logic [31:0] p);
		tick_result_t r;
		r.slot = (s < 0) ? 3'd0 : 3'(s);
		r.found = (s >= 0);
		r.switch_request = sw;
		r.wake = 1'b0;
		r.pending_count = p;
		r.last = 1'b1;
		return r;
	endfunction

	// Work out the results of one accepted item and queue them.
	task automatic ticker_predict(input logic [2:0] k, input logic [15:0] h,
			input logic [63:0] now, input logic dl);
		int s, cnt;
		logic sw;
		logic [31:0] n;
		logic [63:0] per, el, q;
		tick_result_t r;
		tick_result_t res [mctt_pkg::MaxContexts];
		s = -1;
		sw = 1'b0;
		n = '0;
		cnt = 0;
		case (k)
			mctt_pkg::KindRegister: begin
				s = find_live(h);
				if (s < 0 && h != 0) begin
					for (int i = 0; i < mctt_pkg::MaxContexts; i++) begin
						if (!ctx_active[i]) begin
							s = i;
							ctx_handle[i] = h;
							ctx_active[i] = 1'b1;
							ctx_ticks[i] = '0;
							ctx_slice[i] = slice_reg;
							ctx_stamp[i] = now;
							break;
						end
					end
				end
				tick_results_q.push_back(single(s, 1'b0, 32'd0));
			end
			mctt_pkg::KindUnregister: begin
				if (h != 0) begin
					for (int i = 0; i < mctt_pkg::MaxContexts; i++) begin
						if (ctx_handle[i] == h) begin
							ctx_active[i] = 1'b0;
							ctx_handle[i] = '0;
							s = i;
							break;
						end
					end
				end
				tick_results_q.push_back(single(s, 1'b0, 32'd0));
			end
			mctt_pkg::KindGlobalTick: begin
				for (int i = 0; i < mctt_pkg::MaxContexts; i++) begin
					if (ctx_active[i] && ctx_handle[i] != 0) begin
						charge_ticks(i, 32'd1);
						res[cnt] = '{slot: 3'(i), found: 1'b1, switch_request: ctx_switch[i],
							wake: 1'b1, pending_count: 32'd0, last: 1'b0};
						ctx_switch[i] = 1'b0;
						cnt++;
					end
				end
				if (cnt == 0) begin
					r = single(-1, 1'b0, 32'd0);
					tick_results_q.push_back(r);
				end else begin
					res[cnt-1].last = 1'b1;
					for (int i = 0; i < cnt; i++)
						tick_results_q.push_back(res[i]);
				end
			end
			mctt_pkg::KindSelfTick: begin
				s = find_live(h);
				if (s >= 0) begin
					per = (period_reg == 0) ? 64'd1 : {44'd0, period_reg};
					el = now - ctx_stamp[s];
					if (el >= per) begin
						q = el / per;
						n = q[31:0];
						ctx_stamp[s] = ctx_stamp[s] + {32'd0, n} * per;
						charge_ticks(s, n);
					end
					if (dl && ctx_switch[s]) begin
						ctx_switch[s] = 1'b0;
						sw = 1'b1;
					end
				end
				tick_results_q.push_back(single(s, sw, 32'd0));
			end
			mctt_pkg::KindTake: begin
				s = find_live(h);
				if (s >= 0) begin
					n = ctx_ticks[s];
					ctx_ticks[s] = '0;
				end
				tick_results_q.push_back(single(s, 1'b0, n));
			end
			default: tick_results_q.push_back(single(-1, 1'b0, 32'd0));
		endcase
	endtask

	// Offer one item, hold it until taken, then predict. Valid stays high
	// on return so back-to-back items never toggle it within one step.
	task automatic send_item(input logic [2:0] k, input logic [15:0] h,
			input logic [63:0] now, input logic dl);
		if (tx_idle_on && $urandom_range(99) < 30) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < 30);
		end
		in_valid <= 1'b1;
		kind <= k;
		context_handle <= h;
		now_us <= now;
		deliver_now <= dl;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		ticker_predict(k, h, now, dl);
	endtask

	// Drop valid and wait for every queued result, plus slack for the block to settle.
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (tick_results_q.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_reg(input logic [0:0] idx, input logic [19:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == mctt_pkg::CfgTickPeriod)
			period_reg = val;
		else
			slice_reg = val[7:0];
		@(posedge clk);
	endtask

	function automatic logic [15:0] pick_handle();
		int r;
		r = $urandom_range(99);
		if (r < 85)
			return 16'($urandom_range(12, 1));
		if (r < 90)
			return 16'h0000;
		if (r < 95)
			return 16'hFFFF;
		return 16'($urandom);
	endfunction

	// Advance the bench clock: mostly a few periods, sometimes huge jumps or wraps.
	function automatic logic [63:0] pick_now();
		int r;
		logic [63:0] per;
		per = (period_reg == 0) ? 64'd1 : {44'd0, period_reg};
		r = $urandom_range(99);
		if (r < 80)
			wall_us = wall_us + per * $urandom_range(4) + 64'($urandom_range(32'hFFFF));
		else if (r < 92)
			wall_us = wall_us + {$urandom, $urandom};
		else
			wall_us = {$urandom, $urandom};
		return wall_us;
	endfunction

	// Results: check against the oldest expectation; stall at random while rx_idle_on is set.
	always @(posedge clk) begin
		tick_result_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (tick_results_q.size() == 0) begin
				$error("result with no expectation: slot %0d", slot);
				errors++;
			end else begin
				e = tick_results_q.pop_front();
				if (slot !== e.slot) begin
					$error("slot: expected %0d, got %0d", e.slot, slot);
					errors++;
				end
				if (found !== e.found) begin
					$error("found: expected %0d, got %0d", e.found, found);
					errors++;
				end
				if (switch_request !== e.switch_request) begin
					$error("switch_request: expected %0d, got %0d", e.switch_request,
						switch_request);
					errors++;
				end
				if (wake !== e.wake) begin
					$error("wake: expected %0d, got %0d", e.wake, wake);
					errors++;
				end
				if (pending_count !== e.pending_count) begin
					$error("pending_count: expected %0d, got %0d", e.pending_count,
						pending_count);
					errors++;
				end
				if (last !== e.last) begin
					$error("last: expected %0d, got %0d", e.last, last);
					errors++;
				end
			end
		end
		out_stall <= rx_idle_on && ($urandom_range(99) < 30);
	end

	initial begin
		logic [19:0] per_set [6];
		logic [19:0] slice_set [6];
		int r;
		logic [2:0] k;
		logic [15:0] h;
		table_reset();
		// Directed rows; typed expectations are the ones readable at a glance.
		directed = '{
			'{mctt_pkg::KindGlobalTick, 16'h0, 64'h0, 1'b0, 1'b1, 3'd0, 1'b0, 32'd0},
			'{mctt_pkg::KindTake, 16'h0, 64'h0, 1'b0, 1'b1, 3'd0, 1'b0, 32'd0},
			'{3'd7, 16'h5, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b1, 3'd0, 1'b0, 32'd0},
			'{3'd5, 16'hFFFF, 64'h0, 1'b0, 1'b1, 3'd0, 1'b0, 32'd0},
			'{3'd6, 16'h1, 64'h0, 1'b1, 1'b1, 3'd0, 1'b0, 32'd0},
			'{mctt_pkg::KindRegister, 16'h0, 64'd10, 1'b0, 1'b1, 3'd0, 1'b0, 32'd0},
			'{mctt_pkg::KindRegister, 16'h1, 64'd1000, 1'b0, 1'b1, 3'd0, 1'b1, 32'd0},
			'{mctt_pkg::KindRegister, 16'h1, 64'd9000, 1'b0, 1'b1, 3'd0, 1'b1, 32'd0},
			'{mctt_pkg::KindRegister, 16'hFFFF, 64'd0, 1'b0, 1'b1, 3'd1, 1'b1, 32'd0},
			'{mctt_pkg::KindSelfTick, 16'h1, 64'd21007, 1'b1, 1'b0, 3'd0, 1'b0, 32'd0},
			'{mctt_pkg::KindTake, 16'h1, 64'd0, 1'b0, 1'b0, 3'd0, 1'b0, 32'd0},
			'{mctt_pkg::KindGlobalTick, 16'h0, 64'd0, 1'b0, 1'b0, 3'd0, 1'b0, 32'd0},
			'{mctt_pkg::KindGlobalTick, 16'h0, 64'd0, 1'b0, 1'b0, 3'd0, 1'b0, 32'd0},
			'{mctt_pkg::KindGlobalTick, 16'h0, 64'd0, 1'b0, 1'b0, 3'd0, 1'b0, 32'd0},
			'{mctt_pkg::KindSelfTick, 16'h1234, 64'd50000, 1'b1, 1'b1, 3'd0, 1'b0, 32'd0},
			'{mctt_pkg::KindTake, 16'h1234, 64'd0, 1'b0, 1'b1, 3'd0, 1'b0, 32'd0},
			'{mctt_pkg::KindUnregister, 16'hFFFF, 64'd0, 1'b0, 1'b1, 3'd1, 1'b1, 32'd0},
			'{mctt_pkg::KindUnregister, 16'hFFFF, 64'd0, 1'b0, 1'b1, 3'd0, 1'b0, 32'd0},
			'{mctt_pkg::KindRegister, 16'h2, 64'd0, 1'b0, 1'b1, 3'd1, 1'b1, 32'd0},
			'{mctt_pkg::KindRegister, 16'h3, 64'd0, 1'b0, 1'b1, 3'd2, 1'b1, 32'd0},
			'{mctt_pkg::KindRegister, 16'h4, 64'd0, 1'b0, 1'b1, 3'd3, 1'b1, 32'd0},
			'{mctt_pkg::KindRegister, 16'h5, 64'd0, 1'b0, 1'b1, 3'd4, 1'b1, 32'd0},
			'{mctt_pkg::KindRegister, 16'h6, 64'd0, 1'b0, 1'b1, 3'd5, 1'b1, 32'd0},
			'{mctt_pkg::KindRegister, 16'h7, 64'd0, 1'b0, 1'b1, 3'd6, 1'b1, 32'd0},
			'{mctt_pkg::KindRegister, 16'h8, 64'd0, 1'b0, 1'b1, 3'd7, 1'b1, 32'd0},
			// Table full: no slot left for another handle.
			'{mctt_pkg::KindRegister, 16'h9, 64'd0, 1'b0, 1'b1, 3'd0, 1'b0, 32'd0},
			// Eight results, then a self tick whose tick count overflows 32 bits.
			'{mctt_pkg::KindGlobalTick, 16'h0, 64'd0, 1'b0, 1'b0, 3'd0, 1'b0, 32'd0}
		};
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		write_reg(mctt_pkg::CfgTickPeriod, 20'd4000);
		write_reg(mctt_pkg::CfgTimeslice, 20'd3);

		for (int i = 0; i < NumDirected; i++) begin
			send_item(directed[i].kind, directed[i].handle, directed[i].now, directed[i].dl);
			if (directed[i].known) begin
				void'(tick_results_q.pop_back());
				tick_results_q.push_back(single(directed[i].found ? int'(directed[i].slot) : -1,
					1'b0, directed[i].pend));
			end
		end
		drain();
		write_reg(mctt_pkg::CfgTickPeriod, 20'd1);
		send_item(mctt_pkg::KindSelfTick, 16'h2, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1);
		send_item(mctt_pkg::KindTake, 16'h2, 64'd0, 1'b0);
		drain();

		// Settings walked by the random part: defaults, minimum, zero, large, all ones, random.
		per_set = '{20'd4000, 20'd1, 20'd0, 20'd1000000, 20'hFFFFF, 20'($urandom)};
		slice_set = '{20'd3, 20'd1, 20'd0, 20'd255, 20'd255, 20'($urandom_range(255))};
		for (int p = 0; p < 6; p++) begin
			write_reg(mctt_pkg::CfgTickPeriod, per_set[p]);
			write_reg(mctt_pkg::CfgTimeslice, slice_set[p]);
			// One phase runs with no idling on either side.
			tx_idle_on = (p != 2);
			rx_idle_on = (p != 2);
			for (int j = 0; j < 74; j++) begin
				r = $urandom_range(99);
				h = pick_handle();
				if (r < 20) k = mctt_pkg::KindRegister;
				else if (r < 30) k = mctt_pkg::KindUnregister;
				else if (r < 50) k = mctt_pkg::KindGlobalTick;
				else if (r < 78) k = mctt_pkg::KindSelfTick;
				else if (r < 96) k = mctt_pkg::KindTake;
				else k = 3'($urandom_range(7, 5));
				send_item(k, h, pick_now(), 1'($urandom));
				// Hold off once per phase until the block has emptied out.
				if (j == 40) begin
					in_valid <= 1'b0;
					@(posedge clk);
					while (tick_results_q.size() != 0)
						@(posedge clk);
				end
			end
			drain();
		end

		repeat (200) @(posedge clk);
		if (errors == 0)
			$display("** multi_context_timeslice_ticker_unit: PASSED **");
		else
			$display("** multi_context_timeslice_ticker_unit: FAILED **");
		$finish;
	end

	initial begin
		#(64'd40_000_000);
		$display("** multi_context_timeslice_ticker_unit: FAILED **");
		$finish;
	end
endmodule

@@ filelist.f @@
rtl/mctt_pkg.sv
rtl/mctt_datapath.sv
rtl/mctt_ctrl.sv
rtl/multi_context_timeslice_ticker_unit.sv
test/multi_context_timeslice_ticker_unit_tb.sv
